// File: hdl/ccls_pkg.sv
package ccls_pkg;

	// Default lattice size
	localparam int unsigned LAT_WIDTH_DEF  = 256;
	localparam int unsigned LAT_HEIGHT_DEF = 256;

	// Request actions
	localparam logic [1:0] ACT_INTERACT = 2'd0;
	localparam logic [1:0] ACT_WRITE    = 2'd1;
	localparam logic [1:0] ACT_READ     = 2'd2;

	// Neighbor directions
	localparam logic [1:0] DIR_ROW_INC = 2'd0;
	localparam logic [1:0] DIR_ROW_DEC = 2'd1;
	localparam logic [1:0] DIR_COL_INC = 2'd2;
	localparam logic [1:0] DIR_COL_DEC = 2'd3;

	// Event kinds
	localparam logic [1:0] EV_NONE      = 2'd0;
	localparam logic [1:0] EV_SWAP      = 2'd1;
	localparam logic [1:0] EV_PREDATION = 2'd2;
	localparam logic [1:0] EV_REPRO     = 2'd3;

	// Configuration register indexes
	localparam logic [1:0] CFG_MOBILITY  = 2'd0;
	localparam logic [1:0] CFG_PREDATION = 2'd1;
	localparam logic [1:0] CFG_SPECIES   = 2'd2;

	// Configuration reset values
	localparam logic [15:0] MOBILITY_RST  = 16'd16384;
	localparam logic [15:0] PREDATION_RST = 16'd16384;
	localparam logic [2:0]  SPECIES_RST   = 3'd3;
	localparam logic [2:0]  SPECIES_MIN   = 3'd2;

	// Site value modulo species count; ns is at least two, so three
	// compare-subtract steps cover every 3-bit value.
	function automatic logic [2:0] species_mod(input logic [2:0] v, input logic [2:0] ns);
		logic [2:0] r;
		r = v;
		for (int i = 0; i < 3; i++) begin
			if (r >= ns) begin
				r = r - ns;
			end
		end
		return r;
	endfunction

endpackage

// File: hdl/cyclic_competition_lattice_step.sv
// Sequence: an accepted request steps through S_ADDR and S_EVAL, then S_WRA for a swap
// (two sites are written back); the result strobe (done) follows the last of these.
// Flow: busy holds off a new request until the last is through; the single write port of
// the memory forces S_WRA; the receiver cannot stall, each result lasts one cycle.
// Reset: arst_n clears the sequencer, the strobe and the configuration registers;
// the lattice memory is not cleared and each site is undefined until written.
module cyclic_competition_lattice_step
	import ccls_pkg::*;
#(
	parameter int unsigned LATTICE_WIDTH  = LAT_WIDTH_DEF,
	parameter int unsigned LATTICE_HEIGHT = LAT_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// Request channel
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [7:0]  col,
	input  logic [7:0]  row,
	input  logic [1:0]  direction,
	input  logic [15:0] draw,
	input  logic [2:0]  site_value,

	// Result channel
	output logic        done,
	output logic [1:0]  event_kind,
	output logic        counted,
	output logic [2:0]  read_value,

	// Configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int unsigned DEPTH = LATTICE_WIDTH * LATTICE_HEIGHT;
	localparam int unsigned CW    = $clog2(LATTICE_WIDTH);
	localparam int unsigned RW    = $clog2(LATTICE_HEIGHT);
	localparam int unsigned AW    = $clog2(DEPTH);

	localparam logic [AW-1:0] WIDTH_A  = AW'(LATTICE_WIDTH);
	localparam logic [CW-1:0] COL_LAST = CW'(LATTICE_WIDTH - 1);
	localparam logic [RW-1:0] ROW_LAST = RW'(LATTICE_HEIGHT - 1);

	// Sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_ADDR = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;
	localparam logic [1:0] S_WRA  = 2'd3;

	logic [1:0] state_q;

	// Configuration registers
	logic [15:0] mobility_q;
	logic [15:0] predation_q;
	logic [2:0]  species_q;

	// Latched request, coordinates already wrapped onto the torus
	logic [1:0]    act_q;
	logic [CW-1:0] colm_q;
	logic [RW-1:0] rowm_q;
	logic [1:0]    dir_q;
	logic [15:0]   draw_q;
	logic [2:0]    val_q;

	// Site addresses kept for the write-back cycles
	logic [AW-1:0] addr_a_q;
	logic [AW-1:0] addr_p_q;
	logic [2:0]    swap_val_q;

	// Lattice memory: one write port, two registered read ports
	logic [2:0]    lat_mem [DEPTH];
	logic [2:0]    rd_a_q;
	logic [2:0]    rd_p_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [2:0]    mem_wdata;

	// Result registers
	logic       done_q;
	logic [1:0] kind_q;
	logic       counted_q;
	logic [2:0] rdval_q;

	// ------------------------------------------------------------------
	// Coordinate wrap: col and row are 8 bits, so wrap through 256-entry
	// constant tables built at elaboration.
	// ------------------------------------------------------------------
	logic [CW-1:0] col_wrap [256];
	logic [RW-1:0] row_wrap [256];

	for (genvar i = 0; i < 256; i++) begin : g_wrap
		localparam int unsigned CM = i % LATTICE_WIDTH;
		localparam int unsigned RM = i % LATTICE_HEIGHT;
		assign col_wrap[i] = CW'(CM);
		assign row_wrap[i] = RW'(RM);
	end

	logic accept;
	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// ------------------------------------------------------------------
	// Neighbor coordinates and linear addresses, from the latched request
	// ------------------------------------------------------------------
	logic [RW-1:0] row_inc, row_dec, nb_row;
	logic [CW-1:0] col_inc, col_dec, nb_col;
	logic [AW-1:0] addr_a_c, addr_p_c;

	always_comb begin
		row_inc = (rowm_q == ROW_LAST) ? '0 : rowm_q + RW'(1);
		row_dec = (rowm_q == '0) ? ROW_LAST : rowm_q - RW'(1);
		col_inc = (colm_q == COL_LAST) ? '0 : colm_q + CW'(1);
		col_dec = (colm_q == '0) ? COL_LAST : colm_q - CW'(1);
		case (dir_q)
			DIR_ROW_INC: begin
				nb_row = row_inc;
				nb_col = colm_q;
			end
			DIR_ROW_DEC: begin
				nb_row = row_dec;
				nb_col = colm_q;
			end
			DIR_COL_INC: begin
				nb_row = rowm_q;
				nb_col = col_inc;
			end
			default: begin
				nb_row = rowm_q;
				nb_col = col_dec;
			end
		endcase
		addr_a_c = AW'(rowm_q) * WIDTH_A + AW'(colm_q);
		addr_p_c = AW'(nb_row) * WIDTH_A + AW'(nb_col);
	end

	// ------------------------------------------------------------------
	// Event decision, once both sites are read
	// ------------------------------------------------------------------
	logic [2:0]  species_eff;
	logic [16:0] pred_limit;
	logic [1:0]  ev_kind;
	logic        wr_p;
	logic [2:0]  wr_p_data;
	logic        prey_hit;

	always_comb begin
		species_eff = (species_q < SPECIES_MIN) ? SPECIES_MIN : species_q;
		pred_limit  = {1'b0, mobility_q} + {1'b0, predation_q};
		prey_hit    = (rd_p_q != 3'd0) &&
			(species_mod(rd_a_q, species_eff) == rd_p_q - 3'd1);
		ev_kind     = EV_NONE;
		wr_p        = 1'b0;
		wr_p_data   = rd_a_q;
		if (act_q == ACT_INTERACT && rd_a_q != 3'd0) begin
			if (draw_q < mobility_q) begin
				// swap: neighbor takes the active value now, active site next cycle
				ev_kind = EV_SWAP;
				wr_p    = 1'b1;
			end else if ({1'b0, draw_q} < pred_limit) begin
				if (prey_hit) begin
					ev_kind   = EV_PREDATION;
					wr_p      = 1'b1;
					wr_p_data = 3'd0;
				end
			end else if (rd_p_q == 3'd0) begin
				ev_kind = EV_REPRO;
				wr_p    = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Memory write port select
	// ------------------------------------------------------------------
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_a_c;
		mem_wdata = val_q;
		case (state_q)
			S_ADDR: begin
				// site load
				mem_we = (act_q == ACT_WRITE);
			end
			S_EVAL: begin
				mem_we    = wr_p;
				mem_waddr = addr_p_q;
				mem_wdata = wr_p_data;
			end
			S_WRA: begin
				// second half of a swap
				mem_we    = 1'b1;
				mem_waddr = addr_a_q;
				mem_wdata = swap_val_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			lat_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= lat_mem[addr_a_c];
		rd_p_q <= lat_mem[addr_p_c];
	end

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mobility_q  <= MOBILITY_RST;
			predation_q <= PREDATION_RST;
			species_q   <= SPECIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MOBILITY:  mobility_q  <= cfg_data;
				CFG_PREDATION: predation_q <= cfg_data;
				CFG_SPECIES:   species_q   <= cfg_data[2:0];
				default: begin
					// drop writes to unknown indexes
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Request latch (payload, no reset)
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= action;
			colm_q <= col_wrap[col];
			rowm_q <= row_wrap[row];
			dir_q  <= direction;
			draw_q <= draw;
			val_q  <= site_value;
		end
		if (state_q == S_ADDR) begin
			addr_a_q <= addr_a_c;
			addr_p_q <= addr_p_c;
		end
		if (state_q == S_EVAL) begin
			swap_val_q <= rd_p_q;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and result strobe
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			// strobe after the last write-back of the request
			done_q <= (state_q == S_WRA) || (state_q == S_EVAL && ev_kind != EV_SWAP);
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					// hold off the strobe until the second swap write
					if (ev_kind == EV_SWAP) begin
						state_q <= S_WRA;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WRA: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result payload: settle in S_EVAL, kept through S_WRA
	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			kind_q    <= ev_kind;
			counted_q <= (ev_kind != EV_NONE);
			rdval_q   <= (act_q == ACT_READ) ? rd_a_q : 3'd0;
		end
	end

	assign done       = done_q;
	assign event_kind = kind_q;
	assign counted    = counted_q;
	assign read_value = rdval_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_EVAL || $past(state_q) == S_WRA))
		else $error("result strobe without evaluation");

	a_accept_seq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == S_ADDR))
		else $error("accepted request did not start address stage");

	a_idle_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("lattice write while idle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_read_noevent: assert property (@(posedge clk) disable iff (!arst_n)
		(done && read_value != 3'd0) |-> (event_kind == EV_NONE && !counted))
		else $error("read result carries an event");

endmodule
